// File: src/bmc_pkg.sv
package bmc_pkg;

    localparam int unsigned STAMP_W = 32;
    localparam int unsigned CFG_W   = 16;
    localparam int unsigned IDX_W   = 2;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_CLICK  = 2'd1,
        EV_DOUBLE = 2'd2,
        EV_HOLD   = 2'd3
    } event_t;

    typedef enum logic [IDX_W-1:0] {
        REG_DEBOUNCE = 2'd0,
        REG_GAP      = 2'd1,
        REG_HOLD     = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_ms;
        logic [CFG_W-1:0] double_click_gap_ms;
        logic [CFG_W-1:0] hold_ms;
    } cfg_t;

    typedef struct packed {
        logic               last_released;
        logic [STAMP_W-1:0] press_stamp;
        logic [STAMP_W-1:0] release_stamp;
        logic               click_pending;
        logic               double_armed;
        logic               single_allowed;
        logic               skip_release;
    } state_t;

    localparam cfg_t CFG_RESET = '{
        debounce_ms:         16'd20,
        double_click_gap_ms: 16'd250,
        hold_ms:             16'd700
    };

    localparam state_t STATE_RESET = '{
        last_released:  1'b1,
        press_stamp:    '1,
        release_stamp:  '1,
        click_pending:  1'b0,
        double_armed:   1'b0,
        single_allowed: 1'b1,
        skip_release:   1'b0
    };

endpackage

// File: src/bmc_step.sv
module bmc_step
(
    input  bmc_pkg::cfg_t                 cfg,
    input  bmc_pkg::state_t               state,
    input  logic                          pressed,
    input  logic [bmc_pkg::STAMP_W-1:0]   now_ms,
    output bmc_pkg::state_t               state_next,
    output bmc_pkg::event_t               event_code
);

    logic [bmc_pkg::STAMP_W-1:0] since_up;
    logic [bmc_pkg::STAMP_W-1:0] since_down;
    logic [bmc_pkg::STAMP_W-1:0] since_rel_upd;
    logic [bmc_pkg::STAMP_W-1:0] since_press_upd;
    logic [bmc_pkg::STAMP_W-1:0] debounce_ext;
    logic [bmc_pkg::STAMP_W-1:0] gap_ext;
    logic [bmc_pkg::STAMP_W-1:0] hold_ext;
    logic                        press_edge;
    logic                        release_edge;
    bmc_pkg::state_t             mid;
    bmc_pkg::event_t             edge_ev;

    assign debounce_ext = {{(bmc_pkg::STAMP_W-bmc_pkg::CFG_W){1'b0}}, cfg.debounce_ms};
    assign gap_ext      = {{(bmc_pkg::STAMP_W-bmc_pkg::CFG_W){1'b0}}, cfg.double_click_gap_ms};
    assign hold_ext     = {{(bmc_pkg::STAMP_W-bmc_pkg::CFG_W){1'b0}}, cfg.hold_ms};

    assign since_up   = now_ms - state.release_stamp;
    assign since_down = now_ms - state.press_stamp;

    assign press_edge   = pressed && state.last_released && (since_up > debounce_ext);
    assign release_edge = !pressed && !state.last_released && (since_down > debounce_ext);

    // Edge handling: press or accepted release updates stamps and click flags
    always_comb
    begin
        mid     = state;
        edge_ev = bmc_pkg::EV_NONE;
        if (press_edge)
        begin
            mid.press_stamp    = now_ms;
            mid.skip_release   = 1'b0;
            mid.single_allowed = 1'b1;
            mid.double_armed   = (since_up < gap_ext) && !state.double_armed
                                 && state.click_pending;
            mid.click_pending  = 1'b0;
        end
        else if (release_edge && !state.skip_release)
        begin
            mid.release_stamp = now_ms;
            if (!state.double_armed)
            begin
                mid.click_pending = 1'b1;
            end
            else
            begin
                edge_ev            = bmc_pkg::EV_DOUBLE;
                mid.double_armed   = 1'b0;
                mid.click_pending  = 1'b0;
                mid.single_allowed = 1'b0;
            end
        end
    end

    assign since_rel_upd   = now_ms - mid.release_stamp;
    assign since_press_upd = now_ms - mid.press_stamp;

    // Gap expiry and hold; hold wins over everything
    always_comb
    begin
        state_next = mid;
        event_code = edge_ev;
        if (!pressed && (since_rel_upd >= gap_ext) && mid.click_pending
            && !mid.double_armed && mid.single_allowed
            && (edge_ev != bmc_pkg::EV_DOUBLE))
        begin
            event_code               = bmc_pkg::EV_CLICK;
            state_next.click_pending = 1'b0;
        end
        if (pressed && (since_press_upd >= hold_ext))
        begin
            event_code               = bmc_pkg::EV_HOLD;
            state_next.skip_release  = 1'b1;
            state_next.double_armed  = 1'b0;
            state_next.click_pending = 1'b0;
        end
        state_next.last_released = !pressed;
    end

endmodule

// File: src/button_multi_click_classifier.sv
// Button click / double click / hold classifier.
//
// Input stream (s_*): one transfer per pin sample. s_tdata carries the raw
// pin level (1 = pressed) and a free-running 32-bit millisecond stamp.
// Output stream (m_*): exactly one transfer per input sample, carrying the
// event code: none, click, double click or hold.
// Configuration channel (cfg_*): index 0 debounce, 1 double-click gap,
// 2 hold time, 16 bits each; other indexes are dropped. Always ready.
// Write it only while no sample is in flight.
//
// Pipeline: two register stages, the input register, then the result
// register, with the classifier logic and state update between them.
// Throughput: one sample per cycle while the result register is not stalled;
// the state update is the only recurrence. When the receiver stalls, the
// result register holds and the input register, if empty, still takes one
// more sample before s_tready drops.
// Reset: clears both stages, loads default timing values (20/250/700 ms)
// and returns the classifier to released, no click pending.
module button_multi_click_classifier
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [39:0]                   s_tdata,   // [0] pin_level, [32:1] now_ms
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,   // [1:0] event_code
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bmc_pkg::IDX_W-1:0]     cfg_index,
    input  logic [bmc_pkg::CFG_W-1:0]     cfg_data
);

    logic                        in_valid_reg;
    logic                        in_pin_reg;
    logic [bmc_pkg::STAMP_W-1:0] in_now_reg;
    logic                        out_valid_reg;
    bmc_pkg::event_t             out_code_reg;
    bmc_pkg::state_t             state_reg;
    bmc_pkg::state_t             state_next;
    bmc_pkg::cfg_t               cfg_reg;
    bmc_pkg::event_t             step_code;
    logic                        s_xfer;
    logic                        advance;
    logic                        fire;

    // The result slot can take a new value when empty or being drained
    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign s_xfer   = s_tvalid && s_tready;

    assign cfg_ready = 1'b1;

    bmc_step u_step
    (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .pressed    (in_pin_reg),
        .now_ms     (in_now_reg),
        .state_next (state_next),
        .event_code (step_code)
    );

    // Input register stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_xfer)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_xfer)
        begin
            in_pin_reg <= s_tdata[0];
            in_now_reg <= s_tdata[32:1];
        end
    end

    // Classifier state advances once per sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bmc_pkg::STATE_RESET;
        end
        else if (fire)
        begin
            state_reg <= state_next;
        end
    end

    // Result register stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_code_reg <= step_code;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_code_reg};

    // Timing registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= bmc_pkg::CFG_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                bmc_pkg::REG_DEBOUNCE: cfg_reg.debounce_ms         <= cfg_data;
                bmc_pkg::REG_GAP:      cfg_reg.double_click_gap_ms <= cfg_data;
                bmc_pkg::REG_HOLD:     cfg_reg.hold_ms             <= cfg_data;
                default:               cfg_reg                     <= cfg_reg;
            endcase
        end
    end

endmodule

// File: src/bmc_checker.sv
module bmc_checker
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      s_tvalid,
    input logic                      s_tready,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [7:0]                m_tdata,
    input logic                      cfg_ready
);

    // An accepted sample must be followed by a valid result on m_tvalid
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |-> ##2 m_tvalid)
        else $error("no result after accepted sample");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[7:2] == 6'd0))
        else $error("result padding bits not zero");

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result withdrawn while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> $stable(m_tdata))
        else $error("result changed while stalled");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration channel not ready");

endmodule

bind button_multi_click_classifier bmc_checker u_bmc_checker (.*);

// File: verif/bmc_event_checker.sv
module bmc_event_checker
    import bmc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [39:0]        s_tdata,   // [0] pin_level, [32:1] now_ms
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [7:0]         m_tdata,   // [1:0] event_code
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,
    output int unsigned        mismatches,
    output int unsigned        in_flight
);

    cfg_t   timing;
    state_t button;
    event_t expected_events[$];

    // Advance the button state by one pin sample and classify it.
    task automatic classify_sample(input logic pin, input logic [STAMP_W-1:0] now,
                                   output event_t ev);
        logic [STAMP_W-1:0] since_up;
        logic [STAMP_W-1:0] since_down;
        ev         = EV_NONE;
        since_up   = now - button.release_stamp;
        since_down = now - button.press_stamp;

        if (pin && button.last_released && since_up > timing.debounce_ms)
        begin
            button.press_stamp    = now;
            button.skip_release   = 1'b0;
            button.single_allowed = 1'b1;
            button.double_armed   = (since_up < timing.double_click_gap_ms)
                                    && !button.double_armed && button.click_pending;
            button.click_pending  = 1'b0;
        end
        else if (!pin && !button.last_released && since_down > timing.debounce_ms)
        begin
            if (!button.skip_release)
            begin
                button.release_stamp = now;
                if (!button.double_armed)
                    button.click_pending = 1'b1;
                else
                begin
                    ev                    = EV_DOUBLE;
                    button.double_armed   = 1'b0;
                    button.click_pending  = 1'b0;
                    button.single_allowed = 1'b0;
                end
            end
        end

        // stamps may have moved above
        since_up   = now - button.release_stamp;
        since_down = now - button.press_stamp;

        if (!pin && since_up >= timing.double_click_gap_ms && button.click_pending
            && !button.double_armed && button.single_allowed && ev != EV_DOUBLE)
        begin
            ev                   = EV_CLICK;
            button.click_pending = 1'b0;
        end

        // hold wins over anything found above
        if (pin && since_down >= timing.hold_ms)
        begin
            ev                   = EV_HOLD;
            button.skip_release  = 1'b1;
            button.double_armed  = 1'b0;
            button.click_pending = 1'b0;
        end

        button.last_released = !pin;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        event_t ev;
        if (!rst_n)
        begin
            timing = CFG_RESET;
            button = STATE_RESET;
            expected_events.delete();
            in_flight <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_DEBOUNCE: timing.debounce_ms         = cfg_data;
                    REG_GAP:      timing.double_click_gap_ms = cfg_data;
                    REG_HOLD:     timing.hold_ms             = cfg_data;
                    default:      ;
                endcase
            end

            if (s_tvalid && s_tready)
            begin
                classify_sample(s_tdata[0], s_tdata[32:1], ev);
                expected_events.push_back(ev);
            end

            if (m_tvalid && m_tready)
            begin
                if (expected_events.size() == 0)
                begin
                    $error("event_code: no result expected, actual %0d", m_tdata[1:0]);
                    mismatches++;
                end
                else
                begin
                    ev = expected_events.pop_front();
                    if (m_tdata[1:0] !== ev)
                    begin
                        $error("event_code: expected %0d, actual %0d", ev, m_tdata[1:0]);
                        mismatches++;
                    end
                end
            end

            in_flight <= $unsigned(expected_events.size());
        end
    end

endmodule

// File: verif/button_multi_click_classifier_tb.sv
module button_multi_click_classifier_tb;
    import bmc_pkg::*;

    // index with no register behind it; a write there must change nothing
    localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 228;

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [39:0]        s_tdata;    // [0] pin_level, [32:1] now_ms
    logic               m_tvalid;
    logic               m_tready;
    logic [7:0]         m_tdata;    // [1:0] event_code
    logic               cfg_valid;
    logic               cfg_ready;
    logic [IDX_W-1:0]   cfg_index;
    logic [CFG_W-1:0]   cfg_data;
    int unsigned        mismatches;
    int unsigned        in_flight;

    // when set, neither side idles: a stretch of back-to-back transfers
    logic               quiet;

    // timing the block currently runs with, used to aim the sample spacing
    int unsigned        cur_debounce;
    int unsigned        cur_gap;
    int unsigned        cur_hold;

    button_multi_click_classifier i_dut (.*);

    bmc_event_checker i_checker (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Receiver side: stall about a third of the cycles, never while quiet.
    always @(posedge clk)
    begin
        m_tready <= quiet || ($urandom_range(0, 99) >= 32);
    end

    // Offer one pin sample and hold it until the transfer happens; idle the
    // sender at random beforehand.
    task automatic send_sample(input logic pin, input logic [STAMP_W-1:0] now);
        while (!quiet && $urandom_range(0, 99) < 32)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, now, pin};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Keep cfg_valid high across back-to-back writes; the caller drops it.
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // Stop sending and drain every expected result, then let the two
    // pipeline stages settle.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (in_flight != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // Spacing between samples: mostly right around one of the thresholds,
    // so that every compare lands on both sides of its limit.
    function automatic logic [STAMP_W-1:0] pick_delta();
        int unsigned base;
        int unsigned off;
        off = $urandom_range(0, 4);
        case ($urandom_range(0, 7))
            0, 1:    base = cur_debounce;
            2, 3:    base = cur_gap;
            4, 5:    base = cur_hold;
            6:       return $urandom_range(0, cur_hold + cur_gap + 3);
            default: return $urandom_range(0, 30);
        endcase
        return (base + off < 2) ? '0 : base + off - 2;
    endfunction

    initial
    begin
        logic               pin;
        logic [STAMP_W-1:0] now;

        clk       = 1'b0;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        quiet     = 1'b0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, default timing 20/250/700 ms.
        // single click: press, release, gap runs out
        send_sample(1'b0, 32'd0);
        send_sample(1'b1, 32'd100);
        send_sample(1'b0, 32'd150);
        send_sample(1'b0, 32'd300);
        send_sample(1'b0, 32'd400);
        // double click: second press inside the gap, report on its release
        send_sample(1'b1, 32'd1000);
        send_sample(1'b0, 32'd1050);
        send_sample(1'b1, 32'd1100);
        send_sample(1'b0, 32'd1150);
        send_sample(1'b0, 32'd1500);
        // hold, repeated hold, then the release after it is ignored
        send_sample(1'b1, 32'd2000);
        send_sample(1'b1, 32'd2700);
        send_sample(1'b1, 32'd2701);
        send_sample(1'b0, 32'd2750);
        send_sample(1'b0, 32'd3100);
        // release too soon after the press: the edge is lost, no click
        send_sample(1'b1, 32'd4000);
        send_sample(1'b0, 32'd4010);
        send_sample(1'b0, 32'd4500);
        // timestamps wrapping through all ones and zero
        send_sample(1'b1, 32'hFFFF_FF00);
        send_sample(1'b0, 32'h0000_0010);
        send_sample(1'b0, 32'hFFFF_FFFF);
        send_sample(1'b1, 32'h0000_0000);
        send_sample(1'b1, 32'h0000_02BC);
        send_sample(1'b0, 32'h0000_0300);
        wait_idle();

        pin = 1'b0;
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    cur_debounce = 0;     cur_gap = 0;     cur_hold = 0;
                end
                1:
                begin
                    cur_debounce = 65535; cur_gap = 65535; cur_hold = 65535;
                end
                2:
                begin
                    cur_debounce = 20;    cur_gap = 250;   cur_hold = 700;
                end
                3:
                begin
                    cur_debounce = $urandom_range(0, 50);
                    cur_gap      = $urandom_range(0, 400);
                    cur_hold     = $urandom_range(0, 1000);
                end
                4:
                begin
                    cur_debounce = 0;     cur_gap = 65535; cur_hold = 1;
                end
                5:
                begin
                    cur_debounce = 65535; cur_gap = 0;     cur_hold = 65535;
                end
                default:
                begin
                    cur_debounce = $urandom_range(0, 65535);
                    cur_gap      = $urandom_range(0, 65535);
                    cur_hold     = $urandom_range(0, 65535);
                end
            endcase

            // no idling on either side through the default-timing phase
            quiet <= (ph == 2);

            write_reg(REG_UNUSED, CFG_W'($urandom_range(0, 65535)));
            write_reg(REG_DEBOUNCE, CFG_W'(cur_debounce));
            write_reg(REG_GAP, CFG_W'(cur_gap));
            write_reg(REG_HOLD, CFG_W'(cur_hold));
            cfg_valid <= 1'b0;

            // start near the top of the range once so the long waits wrap
            now = (ph == 1) ? 32'hFFF8_0000 : $urandom();

            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if ($urandom_range(0, 99) < 12)
                begin
                    // noise: any level at any time
                    pin = 1'($urandom_range(0, 1));
                    now = $urandom();
                end
                else
                begin
                    // press/release pattern with spacing aimed at the limits
                    if ($urandom_range(0, 99) < 60)
                        pin = !pin;
                    now = now + pick_delta();
                end
                send_sample(pin, now);
            end
            wait_idle();
        end

        quiet <= 1'b0;
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Hard stop far beyond any correct run.
    initial
    begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
